[src/mvsv_pkg.sv]
// Shared types and constants for the MPEG video stream validator.
// No dependencies; the front, queue, back and top level files import this package.
package mvsv_pkg;

    // Byte offset width and zero padding run that ends a scan.
    localparam int LengthBits   = 32;
    localparam int ZeroRunLimit = 256;
    localparam int ZeroRunW     = $clog2(ZeroRunLimit + 1);

    // Queue between the front and the back part.
    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    // Start code ids.
    localparam logic [7:0] PIC_ID      = 8'h00;
    localparam logic [7:0] SLICE_FIRST = 8'h01;
    localparam logic [7:0] SLICE_LAST  = 8'hAF;
    localparam logic [7:0] SEQ_HDR_ID  = 8'hB3;
    localparam logic [7:0] EXT_ID      = 8'hB5;
    localparam logic [7:0] SEQ_END_ID  = 8'hB7;
    localparam logic [7:0] GOP_ID      = 8'hB8;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_SCAN,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        CLS_SLICE,
        CLS_KNOWN,
        CLS_END,
        CLS_UNKNOWN
    } code_cls_t;

    typedef enum logic [2:0] {
        STOP_HEADER    = 3'd0,
        STOP_END       = 3'd1,
        STOP_PAD       = 3'd2,
        STOP_UNKNOWN   = 3'd3,
        STOP_EXHAUSTED = 3'd4
    } stop_t;

    // One classified input word as it travels through the queue.
    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        code_cls_t  cls;
    } word_t;

    // Queue status seen by the front part and the top level.
    typedef struct packed {
        logic [QCntW-1:0] count;
        logic             full;
        logic             empty;
    } q_stat_t;

endpackage

[src/mvsv_stream_if.sv]
// Valid/ready channel interfaces for input bytes and verdicts.
// Depends on nothing; used by the front, back and top level modules.
interface mvsv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       window_first;
    logic       window_last;

    modport source (output valid, output data_byte, output window_first,
                    output window_last, input ready);
    modport sink (input valid, input data_byte, input window_first,
                  input window_last, output ready);
endinterface

interface mvsv_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [31:0] stream_length;
    logic [2:0]  stop_reason;

    modport source (output valid, output accepted, output stream_length,
                    output stop_reason, input ready);
    modport sink (input valid, input accepted, input stream_length,
                  input stop_reason, output ready);
endinterface

[src/mpeg_video_stream_validator_unit.sv]
// MPEG video stream validator: one byte word per cycle while the verdict output is not stalled, one verdict per window.
// The byte that decides a verdict passes the front register and the queue before the verdict register.
// Throughput: one byte per cycle while the verdict is not stalled; the back part updates
// the scan state once per word, and the output register lets it run on.
// Reset: asynchronous, active low; the scanner idles until a window_first byte,
// the queue empties and no verdict is pending. No memory clearing pass.
module mpeg_video_stream_validator_unit
    import mvsv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    mvsv_in_if.sink    bytes,
    mvsv_out_if.source verdict
);

    // Classified word from the front register into the queue.
    word_t   front_word;
    logic    front_valid;
    logic    push;

    // Queue head toward the scan engine.
    word_t   head;
    logic    pop;
    q_stat_t q_stat;

    // Front: accept bytes and tag the start code class of each one.
    mvsv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (bytes),
        .word       (front_word),
        .word_valid (front_valid),
        .word_ready (!q_stat.full)
    );

    // Push whenever the front holds a word and the queue has room.
    assign push = front_valid && !q_stat.full;

    mvsv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (front_word),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    // Back: header check and scan; advance one word per cycle while the
    // verdict register is free or being drained.
    mvsv_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (!q_stat.empty),
        .pop        (pop),
        .verdict    (verdict)
    );

`ifndef SYNTH
    // Queue occupancy never goes past its depth.
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= QCntW'(QDepth))
        else $error("queue overfilled");

    // A rejected window reports zero length.
    a_reject_len: assert property (@(posedge clk) disable iff (!rst_n)
        verdict.valid && !verdict.accepted |-> verdict.stream_length == 32'd0)
        else $error("rejected verdict with nonzero length");

    // Header failure never accepts; end code and padding always accept.
    a_reason_acc: assert property (@(posedge clk) disable iff (!rst_n)
        verdict.valid |->
            ((verdict.stop_reason == STOP_HEADER && !verdict.accepted) ||
             (verdict.stop_reason == STOP_END && verdict.accepted) ||
             (verdict.stop_reason == STOP_PAD && verdict.accepted) ||
             verdict.stop_reason == STOP_UNKNOWN ||
             verdict.stop_reason == STOP_EXHAUSTED))
        else $error("stop reason inconsistent with verdict");

    // Nothing leaves the empty queue.
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");
`endif

endmodule

[src/mvsv_front.sv]
// Front part: accept input words and classify the byte as a start code id.
// Depends on mvsv_pkg and mvsv_in_if.
module mvsv_front
    import mvsv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    mvsv_in_if.sink    bytes,
    output word_t      word,
    output logic       word_valid,
    input  logic       word_ready
);

    logic  valid_reg;
    logic  valid_next;
    word_t word_reg;
    logic  take;

    function automatic code_cls_t classify(input logic [7:0] id);
        code_cls_t cls;
        if (id inside {[SLICE_FIRST:SLICE_LAST]})
            cls = CLS_SLICE;
        else if (id == SEQ_END_ID)
            cls = CLS_END;
        else if (id inside {PIC_ID, SEQ_HDR_ID, EXT_ID, GOP_ID})
            cls = CLS_KNOWN;
        else
            cls = CLS_UNKNOWN;
        return cls;
    endfunction

    assign bytes.ready = !valid_reg || word_ready;
    assign take        = bytes.valid && bytes.ready;

    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else if (word_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload register: load on accept only.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_reg.data  <= bytes.data_byte;
            word_reg.first <= bytes.window_first;
            word_reg.last  <= bytes.window_last;
            word_reg.cls   <= classify(bytes.data_byte);
        end
    end

    assign word       = word_reg;
    assign word_valid = valid_reg;

endmodule

[src/mvsv_queue.sv]
// Short register queue that decouples the front and back parts.
// Depends on mvsv_pkg.
module mvsv_queue
    import mvsv_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  word_t   push_word,
    input  logic    pop,
    output word_t   head,
    output q_stat_t stat
);

    word_t            slot_reg [QDepth];
    logic [QPtrW-1:0] wr_ptr_reg;
    logic [QPtrW-1:0] wr_ptr_next;
    logic [QPtrW-1:0] rd_ptr_reg;
    logic [QPtrW-1:0] rd_ptr_next;
    logic [QCntW-1:0] count_reg;
    logic [QCntW-1:0] count_next;

    function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] ptr);
        if (ptr == QPtrW'(QDepth - 1))
            return '0;
        return ptr + QPtrW'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + QCntW'(1);
        else if (pop && !push)
            count_next = count_reg - QCntW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_word;
    end

    assign head       = slot_reg[rd_ptr_reg];
    assign stat.count = count_reg;
    assign stat.full  = (count_reg == QCntW'(QDepth));
    assign stat.empty = (count_reg == '0);

endmodule

[src/mvsv_back.sv]
// Back part: header check, start code scan and verdict output register.
// Depends on mvsv_pkg and mvsv_out_if.
module mvsv_back
    import mvsv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  word_t     head,
    input  logic      head_valid,
    output logic      pop,
    mvsv_out_if.source verdict
);

    localparam logic [31:0] SEQ_HDR_CODE = {24'h000001, SEQ_HDR_ID};
    localparam logic [LengthBits-1:0] PosMax        = '1;
    localparam logic [LengthBits-1:0] PosHdrCode    = LengthBits'(3);
    localparam logic [LengthBits-1:0] PosHdrFields  = LengthBits'(7);
    localparam logic [LengthBits-1:0] PosHdrLast    = LengthBits'(11);
    localparam logic [LengthBits-1:0] PosLenFloor   = LengthBits'(14);
    localparam logic [LengthBits-1:0] PosScanFirst  = LengthBits'(15);
    localparam logic [LengthBits-1:0] LenFloor      = LengthBits'(12);
    localparam logic [LengthBits-1:0] PadBack       = LengthBits'(ZeroRunLimit + 2);
    localparam logic [11:0]           MinDim        = 12'd8;

    phase_t                phase_reg;
    phase_t                phase_next;
    logic [31:0]           look_reg;
    logic [31:0]           look_next;
    logic [LengthBits-1:0] pos_reg;
    logic [LengthBits-1:0] pos_next;
    logic [ZeroRunW-1:0]   zrun_reg;
    logic [ZeroRunW-1:0]   zrun_next;
    logic [1:0]            slice_reg;
    logic [1:0]            slice_next;
    logic [2:0]            code_reg;
    logic [2:0]            code_next;
    logic [1:0]            skip_reg;
    logic [1:0]            skip_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  out_acc_reg;
    logic [31:0]           out_len_reg;
    stop_t                 out_stop_reg;

    logic                  live;
    logic                  emit;
    logic                  emit_acc;
    logic [LengthBits-1:0] emit_len;
    stop_t                 emit_stop;
    logic                  hdr_bad;
    logic                  b0_zero;
    logic                  start_code;
    logic                  counted_ok;
    logic [11:0]           width_val;
    logic [11:0]           height_val;

    assign pop  = head_valid && (!out_valid_reg || verdict.ready);
    assign live = head.first || phase_reg == PH_HEADER || phase_reg == PH_SCAN;

    // Datapath: next window state and verdict decision for the head word.
    always_comb
    begin
        pos_next   = pos_reg;
        zrun_next  = zrun_reg;
        slice_next = slice_reg;
        code_next  = code_reg;
        skip_next  = skip_reg;
        emit       = 1'b0;
        emit_acc   = 1'b0;
        emit_len   = '0;
        emit_stop  = STOP_HEADER;
        hdr_bad    = 1'b0;

        if (head.first)
        begin
            pos_next   = '0;
            zrun_next  = '0;
            slice_next = '0;
            code_next  = '0;
            skip_next  = '0;
            look_next  = {24'h000000, head.data};
        end
        else
        begin
            if (pos_reg != PosMax)
                pos_next = pos_reg + LengthBits'(1);
            look_next = {look_reg[23:0], head.data};
        end

        width_val  = {look_next[31:24], look_next[23:20]};
        height_val = {look_next[15:8], look_next[7:4]};
        b0_zero    = (look_next[31:24] == 8'h00);
        start_code = b0_zero && look_next[23:16] == 8'h00 && look_next[15:8] == 8'h01;

        if (head.first || phase_reg == PH_HEADER)
        begin
            if (pos_next == PosHdrCode && look_next != SEQ_HDR_CODE)
                hdr_bad = 1'b1;
            if (pos_next == PosHdrFields &&
                (width_val < MinDim || height_val < MinDim ||
                 look_next[19:16] == 4'hF || look_next[3:0] == 4'h0))
                hdr_bad = 1'b1;
            if (hdr_bad || head.last)
            begin
                // Header failure, or window done before any scan: reject.
                emit      = 1'b1;
                emit_stop = (hdr_bad || pos_next != PosHdrLast) ? STOP_HEADER
                                                                 : STOP_EXHAUSTED;
            end
        end
        else if (phase_reg == PH_SCAN)
        begin
            if (pos_next >= PosScanFirst)
            begin
                if (skip_reg != 2'd0)
                    skip_next = skip_reg - 2'd1;
                else
                begin
                    if (b0_zero)
                    begin
                        if (zrun_reg < ZeroRunW'(ZeroRunLimit))
                            zrun_next = zrun_reg + ZeroRunW'(1);
                    end
                    else
                        zrun_next = '0;

                    if (b0_zero && zrun_next >= ZeroRunW'(ZeroRunLimit))
                    begin
                        emit      = 1'b1;
                        emit_acc  = 1'b1;
                        emit_len  = pos_next - PadBack;
                        emit_stop = STOP_PAD;
                    end
                    else if (start_code)
                    begin
                        if (head.cls == CLS_SLICE && slice_reg != 2'd3)
                            slice_next = slice_reg + 2'd1;
                        if (code_reg != 3'd7)
                            code_next = code_reg + 3'd1;
                        case (head.cls)
                            CLS_END:
                            begin
                                emit      = 1'b1;
                                emit_acc  = 1'b1;
                                emit_len  = pos_next + LengthBits'(1);
                                emit_stop = STOP_END;
                            end
                            CLS_SLICE, CLS_KNOWN:
                            begin
                                skip_next = 2'd3;
                                zrun_next = '0;
                            end
                            default:
                            begin
                                emit      = 1'b1;
                                emit_acc  = counted_ok;
                                emit_len  = pos_next - LengthBits'(3);
                                emit_stop = STOP_UNKNOWN;
                            end
                        endcase
                    end
                end
            end

            if (!emit && head.last)
            begin
                emit      = 1'b1;
                emit_acc  = counted_ok;
                emit_len  = (pos_next >= PosLenFloor)
                            ? pos_next - LengthBits'(2) + LengthBits'(skip_next)
                            : LenFloor;
                emit_stop = STOP_EXHAUSTED;
            end
        end
    end

    assign counted_ok = slice_next >= 2'd2 && code_next >= 3'd6;

    // Phase sequencing.
    always_comb
    begin
        phase_next = phase_reg;
        if (pop && live)
        begin
            if (emit)
                phase_next = PH_DONE;
            else if (head.first)
                phase_next = PH_HEADER;
            else if (phase_reg == PH_HEADER && pos_next == PosHdrLast)
                phase_next = PH_SCAN;
        end
    end

    always_comb
    begin
        if (pop && live && emit)
            out_valid_next = 1'b1;
        else if (verdict.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            look_reg      <= '0;
            pos_reg       <= '0;
            zrun_reg      <= '0;
            slice_reg     <= '0;
            code_reg      <= '0;
            skip_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            if (pop && live)
            begin
                look_reg  <= look_next;
                pos_reg   <= pos_next;
                zrun_reg  <= zrun_next;
                slice_reg <= slice_next;
                code_reg  <= code_next;
                skip_reg  <= skip_next;
            end
        end
    end

    // Verdict payload: rejected windows report length zero.
    always_ff @(posedge clk)
    begin
        if (pop && live && emit)
        begin
            out_acc_reg  <= emit_acc;
            out_len_reg  <= emit_acc ? 32'(emit_len) : 32'd0;
            out_stop_reg <= emit_stop;
        end
    end

    assign verdict.valid         = out_valid_reg;
    assign verdict.accepted      = out_acc_reg;
    assign verdict.stream_length = out_len_reg;
    assign verdict.stop_reason   = out_stop_reg;

endmodule
